[rtl/core/sqt_pkg.sv]
`default_nettype none

package sqt_pkg;

    // Keyword list
    localparam int NUM_KW  = 11;
    localparam int KW_BITS = 72;

    localparam logic [KW_BITS-1:0] KW_TEXT [NUM_KW] = '{
        {"SELECT", 24'h0}, {"FROM", 40'h0}, {"WHERE", 32'h0}, {"INSERT", 24'h0},
        {"INTO", 40'h0}, {"VALUES", 24'h0}, {"UPDATE", 24'h0}, {"SET", 48'h0},
        {"DELETE", 24'h0}, {"UNION", 32'h0}, "INTERSECT"
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd6, 4'd4, 4'd5, 4'd6, 4'd4, 4'd6, 4'd6, 4'd3, 4'd6, 4'd5, 4'd9
    };
    localparam logic [NUM_KW-1:0] ALL_CAND = '1;
    localparam logic [3:0] LEN_MAX = 4'd15;

    // Event kinds
    localparam logic [1:0] EV_CHAR  = 2'd0;
    localparam logic [1:0] EV_CLOSE = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;

    // Token classes
    localparam logic [2:0] CLS_KEYWORD = 3'd0;
    localparam logic [2:0] CLS_IDENT   = 3'd1;
    localparam logic [2:0] CLS_NUMBER  = 3'd2;
    localparam logic [2:0] CLS_STRING  = 3'd3;
    localparam logic [2:0] CLS_OPER    = 3'd4;

    localparam logic [7:0] QUOTE_CHAR      = 8'h27;
    localparam logic [7:0] UNDERSCORE_CHAR = 8'h5F;

    // Results per item and queue depth
    localparam int MAX_RES    = 4;
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] cls;
        logic [7:0] ch;
        logic [3:0] kwn;
    } result_t;

    typedef struct packed {
        logic [2:0]                 count;
        result_t [MAX_RES-1:0]      res;
    } bundle_t;

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_oper(logic [7:0] c);
        return c == "=" || c == "<" || c == ">" || c == "," || c == ";" ||
               c == "(" || c == ")";
    endfunction

    function automatic result_t make_res(logic [1:0] kind, logic [2:0] cls, logic [7:0] ch);
        result_t r;
        r.kind = kind;
        r.cls  = cls;
        r.ch   = ch;
        r.kwn  = '0;
        return r;
    endfunction

    // Drop keywords that do not match character c at position len or have no position len
    function automatic logic [NUM_KW-1:0] kw_narrow(logic [NUM_KW-1:0] cand,
                                                   logic [3:0] len, logic [7:0] c);
        logic [NUM_KW-1:0] r;
        int                k;
        r = cand;
        for (k = 0; k < NUM_KW; k++) begin
            if (len < KW_LEN[k]) begin
                if (KW_TEXT[k][KW_BITS - 1 - 8 * int'(len) -: 8] != c) begin
                    r[k] = 1'b0;
                end
            end else begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    // Close event of a word: keyword when a full-length candidate survives
    function automatic result_t word_close(logic [NUM_KW-1:0] cand, logic [3:0] len);
        result_t r;
        int      k;
        r = make_res(EV_CLOSE, CLS_IDENT, 8'h00);
        for (k = 0; k < NUM_KW; k++) begin
            if (cand[k] && KW_LEN[k] == len) begin
                r.cls = CLS_KEYWORD;
                r.kwn = 4'(k);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/sql_query_tokenizer.sv]
// Results of an item pass through the result queue and then the output register.
// Throughput: one item per cycle while each causes at most one result and m_ready is
// high; results of one item leave in turn, buffered by a four-item result queue.
// Reset: synchronous active-low aresetn returns the lexer to idle with all keyword
// candidates set and empties the queue and output register.
`default_nettype none

module sql_query_tokenizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_text_byte,
    input  wire logic        s_byte_present,
    input  wire logic        s_end_of_text,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_event_kind,
    output logic [2:0]       m_token_class,
    output logic [7:0]       m_char_out,
    output logic [3:0]       m_keyword_number,
    output logic             m_last_of_run
);

    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    sqt_pkg::bundle_t  push_data;
    sqt_pkg::bundle_t  head;

    sqt_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .s_byte_present (s_byte_present),
        .s_end_of_text  (s_end_of_text),
        .fifo_full      (full),
        .push           (push),
        .push_data      (push_data)
    );

    sqt_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    sqt_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head             (head),
        .empty            (empty),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_token_class    (m_token_class),
        .m_char_out       (m_char_out),
        .m_keyword_number (m_keyword_number),
        .m_last_of_run    (m_last_of_run)
    );

endmodule

`default_nettype wire

[rtl/core/sqt_front.sv]
`default_nettype none

module sqt_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [7:0]      s_text_byte,
    input  wire logic            s_byte_present,
    input  wire logic            s_end_of_text,
    input  wire logic            fifo_full,
    output logic                 push,
    output sqt_pkg::bundle_t     push_data
);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_WORD   = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_STRING = 2'd3
    } mode_t;

    mode_t                        mode_reg, mode_next;
    logic [sqt_pkg::NUM_KW-1:0]   cand_reg, cand_next;
    logic [3:0]                   len_reg, len_next;
    logic [2:0]                   n;
    logic                         reopen;
    logic                         accept;
    sqt_pkg::bundle_t             bundle;

    assign s_ready = !fifo_full;
    assign accept  = s_valid && s_ready;

    // Classify the byte and collect the results it causes
    always_comb begin
        mode_next  = mode_reg;
        cand_next  = cand_reg;
        len_next   = len_reg;
        n          = '0;
        reopen     = 1'b0;
        bundle     = '0;

        if (s_byte_present) begin
            case (mode_reg)
                MODE_STRING: begin
                    if (s_text_byte == sqt_pkg::QUOTE_CHAR) begin
                        bundle.res[n[1:0]] = sqt_pkg::make_res(sqt_pkg::EV_CLOSE,
                            sqt_pkg::CLS_STRING, 8'h00);
                        n = n + 3'd1;
                        mode_next = MODE_IDLE;
                    end else begin
                        bundle.res[n[1:0]] = sqt_pkg::make_res(sqt_pkg::EV_CHAR,
                            sqt_pkg::CLS_STRING, s_text_byte);
                        n = n + 3'd1;
                    end
                end
                MODE_WORD: begin
                    if (sqt_pkg::is_letter(s_text_byte) || sqt_pkg::is_digit(s_text_byte) ||
                        s_text_byte == sqt_pkg::UNDERSCORE_CHAR) begin
                        cand_next = sqt_pkg::kw_narrow(cand_reg, len_reg, s_text_byte);
                        len_next  = (len_reg == sqt_pkg::LEN_MAX) ? len_reg : len_reg + 4'd1;
                        bundle.res[n[1:0]] = sqt_pkg::make_res(sqt_pkg::EV_CHAR,
                            sqt_pkg::CLS_IDENT, s_text_byte);
                        n = n + 3'd1;
                    end else begin
                        bundle.res[n[1:0]] = sqt_pkg::word_close(cand_reg, len_reg);
                        n = n + 3'd1;
                        mode_next = MODE_IDLE;
                        cand_next = sqt_pkg::ALL_CAND;
                        len_next  = '0;
                        reopen    = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (sqt_pkg::is_digit(s_text_byte)) begin
                        bundle.res[n[1:0]] = sqt_pkg::make_res(sqt_pkg::EV_CHAR,
                            sqt_pkg::CLS_NUMBER, s_text_byte);
                        n = n + 3'd1;
                    end else begin
                        bundle.res[n[1:0]] = sqt_pkg::make_res(sqt_pkg::EV_CLOSE,
                            sqt_pkg::CLS_NUMBER, 8'h00);
                        n = n + 3'd1;
                        mode_next = MODE_IDLE;
                        reopen    = 1'b1;
                    end
                end
                default: begin
                    reopen = 1'b1;
                end
            endcase

            // Open a new token from idle
            if (reopen) begin
                if (sqt_pkg::is_letter(s_text_byte)) begin
                    mode_next = MODE_WORD;
                    cand_next = sqt_pkg::kw_narrow(sqt_pkg::ALL_CAND, 4'd0, s_text_byte);
                    len_next  = 4'd1;
                    bundle.res[n[1:0]] = sqt_pkg::make_res(sqt_pkg::EV_CHAR,
                        sqt_pkg::CLS_IDENT, s_text_byte);
                    n = n + 3'd1;
                end else if (sqt_pkg::is_digit(s_text_byte)) begin
                    mode_next = MODE_NUMBER;
                    bundle.res[n[1:0]] = sqt_pkg::make_res(sqt_pkg::EV_CHAR,
                        sqt_pkg::CLS_NUMBER, s_text_byte);
                    n = n + 3'd1;
                end else if (s_text_byte == sqt_pkg::QUOTE_CHAR) begin
                    mode_next = MODE_STRING;
                end else if (sqt_pkg::is_oper(s_text_byte)) begin
                    bundle.res[n[1:0]] = sqt_pkg::make_res(sqt_pkg::EV_CHAR,
                        sqt_pkg::CLS_OPER, s_text_byte);
                    n = n + 3'd1;
                    bundle.res[n[1:0]] = sqt_pkg::make_res(sqt_pkg::EV_CLOSE,
                        sqt_pkg::CLS_OPER, s_text_byte);
                    n = n + 3'd1;
                end
            end
        end

        // Close any open token, then report end of input
        if (s_end_of_text) begin
            case (mode_next)
                MODE_WORD: begin
                    bundle.res[n[1:0]] = sqt_pkg::word_close(cand_next, len_next);
                    n = n + 3'd1;
                end
                MODE_NUMBER: begin
                    bundle.res[n[1:0]] = sqt_pkg::make_res(sqt_pkg::EV_CLOSE,
                        sqt_pkg::CLS_NUMBER, 8'h00);
                    n = n + 3'd1;
                end
                MODE_STRING: begin
                    bundle.res[n[1:0]] = sqt_pkg::make_res(sqt_pkg::EV_CLOSE,
                        sqt_pkg::CLS_STRING, 8'h00);
                    n = n + 3'd1;
                end
                default: begin
                end
            endcase
            bundle.res[n[1:0]] = sqt_pkg::make_res(sqt_pkg::EV_END, 3'd0, 8'h00);
            n = n + 3'd1;
            mode_next = MODE_IDLE;
            cand_next = sqt_pkg::ALL_CAND;
            len_next  = '0;
        end

        bundle.count = n;
    end

    assign push      = accept && (n != 3'd0);
    assign push_data = bundle;

    // Hold lexer state, advance on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            cand_reg <= sqt_pkg::ALL_CAND;
            len_reg  <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            cand_reg <= cand_next;
            len_reg  <= len_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/sqt_fifo.sv]
`default_nettype none

module sqt_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire sqt_pkg::bundle_t  push_data,
    output logic                   full,
    input  wire logic              pop,
    output sqt_pkg::bundle_t       head,
    output logic                   empty
);

    localparam int PTR_W = $clog2(sqt_pkg::FIFO_DEPTH);

    sqt_pkg::bundle_t  mem_reg [sqt_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]    fill_reg;

    assign full  = (fill_reg == (PTR_W+1)'(sqt_pkg::FIFO_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Store incoming bundles
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + (PTR_W+1)'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - (PTR_W+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/sqt_back.sv]
`default_nettype none

module sqt_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sqt_pkg::bundle_t  head,
    input  wire logic              empty,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_event_kind,
    output logic [2:0]             m_token_class,
    output logic [7:0]             m_char_out,
    output logic [3:0]             m_keyword_number,
    output logic                   m_last_of_run
);

    logic [1:0]        idx_reg;
    logic              m_valid_reg;
    sqt_pkg::result_t  res_reg;
    logic              last_reg;
    logic              load;
    logic              at_last;

    assign load    = !empty && (!m_valid_reg || m_ready);
    assign at_last = ({1'b0, idx_reg} == head.count - 3'd1);
    assign pop     = load && at_last;

    // Unroll the head bundle into the output register, one result a cycle while m_ready allows
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
            idx_reg     <= at_last ? 2'd0 : idx_reg + 2'd1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Hold result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg  <= head.res[idx_reg];
            last_reg <= at_last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_event_kind     = res_reg.kind;
    assign m_token_class    = res_reg.cls;
    assign m_char_out       = res_reg.ch;
    assign m_keyword_number = res_reg.kwn;
    assign m_last_of_run    = last_reg;

endmodule

`default_nettype wire
